>>> rtl/qbez_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package qbez_pkg;

   localparam int COORD_BITS  = 16;
   localparam int STEP_SHIFT  = 6;
   localparam int STEPS       = 1 << STEP_SHIFT;
   localparam int STEP_BITS   = 6;
   localparam int WEIGHT_BITS = STEP_SHIFT + 1;
   localparam int PROD_BITS   = COORD_BITS + WEIGHT_BITS + 1;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic [WEIGHT_BITS-1:0]       weight_type;
   typedef logic signed [PROD_BITS-1:0]  prod_type;
   typedef logic [STEP_BITS-1:0]         step_type;

   typedef struct packed {
      step_type step;
      logic     last;
   } tag_type;

   localparam step_type   LAST_STEP  = step_type'(STEPS - 1);
   localparam weight_type FULL_WEIGHT = weight_type'(STEPS);

   function automatic prod_type weigh(coord_type c, weight_type w);
      prod_type cw;
      prod_type ww;
      cw = prod_type'(c);
      ww = prod_type'({1'b0, w});
      return cw * ww;
   endfunction

   function automatic coord_type blend_shift(prod_type near_start, prod_type near_end);
      prod_type sum;
      sum = near_start + near_end;
      return sum[STEP_SHIFT +: COORD_BITS];
   endfunction

endpackage

`default_nettype wire

>>> rtl/qbez_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface qbez_req_if;
   logic                 valid;
   logic                 ready;
   qbez_pkg::coord_type  start_x;
   qbez_pkg::coord_type  start_y;
   qbez_pkg::coord_type  ctrl_x;
   qbez_pkg::coord_type  ctrl_y;
   qbez_pkg::coord_type  end_x;
   qbez_pkg::coord_type  end_y;

   modport source (output valid, start_x, start_y, ctrl_x, ctrl_y, end_x, end_y,
                   input ready);
   modport sink (input valid, start_x, start_y, ctrl_x, ctrl_y, end_x, end_y,
                 output ready);
endinterface

interface qbez_rsp_if;
   logic                 valid;
   logic                 ready;
   qbez_pkg::coord_type  curve_x;
   qbez_pkg::coord_type  curve_y;
   qbez_pkg::step_type   step_index;
   logic                 last_point;

   modport source (output valid, curve_x, curve_y, step_index, last_point,
                   input ready);
   modport sink (input valid, curve_x, curve_y, step_index, last_point,
                 output ready);
endinterface

`default_nettype wire

>>> rtl/quadratic_bezier_point_generator_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Each request beat on req_chan (start, control and end points in signed Q1.14) yields
// 64 curve point beats on rsp_chan, one per cycle unless rsp_chan stalls, step 0 first
// (equal to the end point) and the final one flagged by last_point; a new request is
// taken in the cycle its predecessor issues its last step, so curves follow each other
// without gaps. Points pass through four register stages (weighting products, first
// blend, second products, final blend into the output register), which follow the
// step sequencer that holds the request's points and counts the steps.
// A stalled rsp_chan holds the whole pipeline and the sequencer.
module quadratic_bezier_point_generator_top (
   input  wire             clock,
   input  wire             reset,
   qbez_req_if.sink        req_chan,
   qbez_rsp_if.source      rsp_chan
);

   logic                  advance;
   logic                  req_take;

   logic                  gen_active_ff;
   qbez_pkg::step_type    step_ff;
   qbez_pkg::coord_type   sx_ff, sy_ff, cx_ff, cy_ff, ex_ff, ey_ff;

   qbez_pkg::weight_type  w_in, wn_in;
   qbez_pkg::tag_type     tag_in;

   logic                  s1_valid_ff;
   qbez_pkg::tag_type     s1_tag_ff;
   qbez_pkg::weight_type  s1_w_ff, s1_wn_ff;
   qbez_pkg::prod_type    s1_axs_ff, s1_axc_ff, s1_ays_ff, s1_ayc_ff;
   qbez_pkg::prod_type    s1_bxc_ff, s1_bxe_ff, s1_byc_ff, s1_bye_ff;

   logic                  s2_valid_ff;
   qbez_pkg::tag_type     s2_tag_ff;
   qbez_pkg::weight_type  s2_w_ff, s2_wn_ff;
   qbez_pkg::coord_type   s2_ax_ff, s2_ay_ff, s2_bx_ff, s2_by_ff;

   logic                  s3_valid_ff;
   qbez_pkg::tag_type     s3_tag_ff;
   qbez_pkg::prod_type    s3_pxa_ff, s3_pxb_ff, s3_pya_ff, s3_pyb_ff;

   logic                  s4_valid_ff;
   qbez_pkg::tag_type     s4_tag_ff;
   qbez_pkg::coord_type   s4_x_ff, s4_y_ff;

   assign advance        = !s4_valid_ff || rsp_chan.ready;
   assign req_chan.ready = !gen_active_ff || (advance && step_ff == qbez_pkg::LAST_STEP);
   assign req_take       = req_chan.valid && req_chan.ready;

   assign w_in   = {1'b0, step_ff};
   assign wn_in  = qbez_pkg::FULL_WEIGHT - {1'b0, step_ff};
   assign tag_in = {step_ff, (step_ff == qbez_pkg::LAST_STEP)};

   always_ff @(posedge clock) begin
      if (reset) begin
         gen_active_ff <= 1'b0;
         step_ff       <= '0;
      end else if (req_take) begin
         gen_active_ff <= 1'b1;
         step_ff       <= '0;
      end else if (advance && gen_active_ff) begin
         if (step_ff == qbez_pkg::LAST_STEP) begin
            gen_active_ff <= 1'b0;
         end
         step_ff <= step_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         sx_ff <= req_chan.start_x;
         sy_ff <= req_chan.start_y;
         cx_ff <= req_chan.ctrl_x;
         cy_ff <= req_chan.ctrl_y;
         ex_ff <= req_chan.end_x;
         ey_ff <= req_chan.end_y;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= gen_active_ff;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_tag_ff <= tag_in;
         s1_w_ff   <= w_in;
         s1_wn_ff  <= wn_in;
         s1_axs_ff <= qbez_pkg::weigh(sx_ff, w_in);
         s1_axc_ff <= qbez_pkg::weigh(cx_ff, wn_in);
         s1_ays_ff <= qbez_pkg::weigh(sy_ff, w_in);
         s1_ayc_ff <= qbez_pkg::weigh(cy_ff, wn_in);
         s1_bxc_ff <= qbez_pkg::weigh(cx_ff, w_in);
         s1_bxe_ff <= qbez_pkg::weigh(ex_ff, wn_in);
         s1_byc_ff <= qbez_pkg::weigh(cy_ff, w_in);
         s1_bye_ff <= qbez_pkg::weigh(ey_ff, wn_in);

         s2_tag_ff <= s1_tag_ff;
         s2_w_ff   <= s1_w_ff;
         s2_wn_ff  <= s1_wn_ff;
         s2_ax_ff  <= qbez_pkg::blend_shift(s1_axs_ff, s1_axc_ff);
         s2_ay_ff  <= qbez_pkg::blend_shift(s1_ays_ff, s1_ayc_ff);
         s2_bx_ff  <= qbez_pkg::blend_shift(s1_bxc_ff, s1_bxe_ff);
         s2_by_ff  <= qbez_pkg::blend_shift(s1_byc_ff, s1_bye_ff);

         s3_tag_ff <= s2_tag_ff;
         s3_pxa_ff <= qbez_pkg::weigh(s2_ax_ff, s2_w_ff);
         s3_pxb_ff <= qbez_pkg::weigh(s2_bx_ff, s2_wn_ff);
         s3_pya_ff <= qbez_pkg::weigh(s2_ay_ff, s2_w_ff);
         s3_pyb_ff <= qbez_pkg::weigh(s2_by_ff, s2_wn_ff);

         s4_tag_ff <= s3_tag_ff;
         s4_x_ff   <= qbez_pkg::blend_shift(s3_pxa_ff, s3_pxb_ff);
         s4_y_ff   <= qbez_pkg::blend_shift(s3_pya_ff, s3_pyb_ff);
      end
   end

   assign rsp_chan.valid      = s4_valid_ff;
   assign rsp_chan.curve_x    = s4_x_ff;
   assign rsp_chan.curve_y    = s4_y_ff;
   assign rsp_chan.step_index = s4_tag_ff.step;
   assign rsp_chan.last_point = s4_tag_ff.last;

endmodule

`default_nettype wire
